/* rtl/tolerance_bin_peak_accumulator_defines.svh */
// Assertion macros used by the port-level checker.
`ifndef TOLERANCE_BIN_PEAK_ACCUMULATOR_DEFINES_SVH
`define TOLERANCE_BIN_PEAK_ACCUMULATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TBPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define TBPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/tbpa_pkg.sv */
// Shared opcodes and constants of the tolerance bin peak accumulator.
package tbpa_pkg;
  localparam int MaxBinsDefault = 64;
  localparam int OpW = 3;
  localparam int SumW = 48;
  localparam logic [OpW-1:0] OP_CLEAR = 3'd0;
  localparam logic [OpW-1:0] OP_LOAD  = 3'd1;
  localparam logic [OpW-1:0] OP_START = 3'd2;
  localparam logic [OpW-1:0] OP_PEAK  = 3'd3;
  localparam logic [OpW-1:0] OP_END   = 3'd4;
  localparam logic [SumW-1:0] SUM_MAX = {SumW{1'b1}};
  // Input tdata: opcode, bin_center, bin_half_width, scale_weight, row_tag,
  // peak_mz, peak_intensity, padded to 176 bits.
  localparam int InW = 176;
  // Output tdata: bin_index, weighted_sum, result_row, padded to 72 bits.
  localparam int OutW = 72;
endpackage

/* rtl/tolerance_bin_peak_accumulator.sv */
// Top level of the tolerance bin peak accumulator.
// Items are processed one at a time. Load bin passes through S_LD1 as well
// when it overlaps the bin before it, to write that bin's snapped upper edge.
// Start spectrum and clear table sweep the accumulator memory, one entry a
// cycle, over all MAX_BINS entries. A peak steps through S_SKRD and S_SKCK
// for each bin that the search start skips, then through S_WKRD and S_WKCK
// for each candidate bin visited, reading the edge and accumulator memories,
// and through S_WKWR to write the sum back when the peak falls in the bin.
// End spectrum streams one result per loaded bin through a read, a multiply
// and an output register; a new read is issued only once the previous result
// is leaving. After reset the accumulator is cleared before items are taken.
module tolerance_bin_peak_accumulator import tbpa_pkg::*; #(
  parameter int MAX_BINS = MaxBinsDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // opcode[2:0], bin_center[34:3], bin_half_width[58:35], scale_weight[90:59],
  // row_tag[106:91], peak_mz[138:107], peak_intensity[170:139], zero pad.
  input  logic [InW-1:0]  s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  // bin_index[5:0], weighted_sum[53:6], result_row[69:54], zero pad.
  output logic [OutW-1:0] m_tdata,
  // last_bin.
  output logic            m_tlast
);
  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam logic [CW-1:0] NMAX = CW'(MAX_BINS);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_LD1   = 4'd3;
  localparam logic [3:0] S_SKRD  = 4'd4;
  localparam logic [3:0] S_SKCK  = 4'd5;
  localparam logic [3:0] S_WKRD  = 4'd6;
  localparam logic [3:0] S_WKCK  = 4'd7;
  localparam logic [3:0] S_WKWR  = 4'd8;
  localparam logic [3:0] S_DRAIN = 4'd9;

  logic [3:0] state;
  logic [CW-1:0] loaded_bins, search_start, idx;
  logic [31:0] widest_half, prev_orig_lower, prev_orig_upper, first_lower;
  logic past_range;
  logic [31:0] held_weight;
  logic [15:0] held_row;
  logic [31:0] pk_mz, pk_int, min_start, ld_mid;
  logic [AW-1:0] ld_idx;

  // Memory ports.
  logic lo_we, hi_we, acc_we;
  logic [AW-1:0] lo_wa, hi_wa, acc_wa, rd_a;
  logic [31:0] lo_wd, hi_wd, lo_rd, hi_rd;
  logic [SumW-1:0] acc_wd, acc_rd;

  tbpa_ram #(.Width(32), .Depth(MAX_BINS)) u_lo (.clk, .we(lo_we), .waddr(lo_wa),
    .wdata(lo_wd), .raddr(rd_a), .rdata(lo_rd));
  tbpa_ram #(.Width(32), .Depth(MAX_BINS)) u_hi (.clk, .we(hi_we), .waddr(hi_wa),
    .wdata(hi_wd), .raddr(rd_a), .rdata(hi_rd));
  tbpa_ram #(.Width(SumW), .Depth(MAX_BINS)) u_acc (.clk, .we(acc_we), .waddr(acc_wa),
    .wdata(acc_wd), .raddr(rd_a), .rdata(acc_rd));

  logic [2:0] opcode;
  logic [31:0] in_center, in_weight, in_mz, in_int;
  logic [23:0] in_half;
  logic [15:0] in_row;
  assign opcode    = s_tdata[2:0];
  assign in_center = s_tdata[34:3];
  assign in_half   = s_tdata[58:35];
  assign in_weight = s_tdata[90:59];
  assign in_row    = s_tdata[106:91];
  assign in_mz     = s_tdata[138:107];
  assign in_int    = s_tdata[170:139];

  logic acc_in;
  assign s_tready = (state == S_IDLE);
  assign acc_in = s_tvalid && s_tready;

  // Load-bin edges.
  logic [31:0] half32, new_lo, new_hi;
  logic [32:0] hi_sum;
  logic [33:0] snap_sum;
  assign half32 = {8'd0, in_half};
  assign new_lo = (in_center >= half32) ? in_center - half32 : 32'd0;
  assign hi_sum = {1'b0, in_center} + {1'b0, half32};
  assign new_hi = hi_sum[32] ? 32'hFFFF_FFFF : hi_sum[31:0];
  assign snap_sum = {2'd0, prev_orig_lower} + {2'd0, prev_orig_upper}
                  + {2'd0, new_lo} + {2'd0, new_hi};

  // Drain pipeline: read, multiply, output register.
  logic d_v0, d_v1, d_last0, d_last1;
  logic [AW-1:0] d_i0, d_i1;
  logic [SumW-1:0] scaled;
  logic [1:0] in_flight;
  logic out_full, out_take, issue;
  assign out_take = m_tvalid && m_tready;
  // Issue only when no result is in flight and the output register is empty or being taken.
  assign issue = (state == S_DRAIN) && (idx < loaded_bins)
               && ({1'b0, in_flight} + {2'b0, out_full} - {2'b0, out_take} < 3'd1);

  tbpa_scale u_scale (.clk, .sum(acc_rd), .weight(held_weight), .scaled(scaled));

  logic [48:0] acc_add;
  assign acc_add = {1'b0, acc_rd} + {17'd0, pk_int};

  always_comb begin
    lo_we = 1'b0; hi_we = 1'b0; acc_we = 1'b0;
    lo_wa = ld_idx; hi_wa = ld_idx; acc_wa = idx[AW-1:0];
    lo_wd = new_lo; hi_wd = new_hi; acc_wd = '0;
    rd_a = idx[AW-1:0];
    case (state)
      S_INIT, S_CLR: begin
        acc_we = 1'b1;
      end
      S_IDLE: begin
        if (acc_in && opcode == OP_LOAD && loaded_bins != NMAX) begin
          lo_we = 1'b1; hi_we = 1'b1;
          lo_wa = loaded_bins[AW-1:0]; hi_wa = loaded_bins[AW-1:0];
          if (loaded_bins != '0 && prev_orig_upper > new_lo) begin
            lo_wd = snap_sum[33:2];
          end
        end
      end
      S_LD1: begin
        hi_we = 1'b1; hi_wa = ld_idx - AW'(1); hi_wd = ld_mid;
      end
      S_SKRD: rd_a = search_start[AW-1:0];
      S_WKWR: begin
        acc_we = 1'b1;
        acc_wd = acc_add[48] ? SUM_MAX : acc_add[SumW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      loaded_bins <= '0; search_start <= '0; past_range <= 1'b0;
      widest_half <= '0; prev_orig_lower <= '0; prev_orig_upper <= '0;
      first_lower <= '0; held_weight <= '0; held_row <= '0;
      d_v0 <= 1'b0; d_v1 <= 1'b0; m_tvalid <= 1'b0; in_flight <= '0; out_full <= 1'b0;
    end else begin
      d_v0 <= issue;
      d_i0 <= idx[AW-1:0];
      d_last0 <= (idx + CW'(1) == loaded_bins);
      d_v1 <= d_v0; d_i1 <= d_i0; d_last1 <= d_last0;
      in_flight <= in_flight + {1'b0, issue} - {1'b0, d_v1};
      if (d_v1) begin
        m_tvalid <= 1'b1; out_full <= 1'b1;
        m_tdata <= {2'd0, held_row, scaled, 6'(d_i1)};
        m_tlast <= d_last1;
      end else if (out_take) begin
        m_tvalid <= 1'b0; out_full <= 1'b0;
      end
      case (state)
        S_INIT, S_CLR: begin
          idx <= idx + CW'(1);
          if (idx == NMAX - CW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          idx <= '0;
          if (acc_in) begin
            case (opcode)
              OP_CLEAR: begin
                loaded_bins <= '0; widest_half <= '0; prev_orig_lower <= '0;
                prev_orig_upper <= '0; first_lower <= '0; search_start <= '0;
                past_range <= 1'b0; state <= S_CLR;
              end
              OP_LOAD: begin
                if (loaded_bins != NMAX) begin
                  if (half32 > widest_half) widest_half <= half32;
                  if (loaded_bins == '0) first_lower <= new_lo;
                  prev_orig_lower <= new_lo; prev_orig_upper <= new_hi;
                  loaded_bins <= loaded_bins + CW'(1);
                  ld_idx <= loaded_bins[AW-1:0];
                  ld_mid <= snap_sum[33:2];
                  if (loaded_bins != '0 && prev_orig_upper > new_lo) state <= S_LD1;
                end
              end
              OP_START: begin
                held_weight <= in_weight; held_row <= in_row;
                search_start <= '0; past_range <= 1'b0; state <= S_CLR;
              end
              OP_PEAK: begin
                pk_mz <= in_mz; pk_int <= in_int;
                min_start <= in_mz - widest_half;
                if (loaded_bins != '0 && !past_range && in_mz >= first_lower) begin
                  if (in_mz > prev_orig_upper) past_range <= 1'b1;
                  else if (in_mz >= widest_half) state <= S_SKRD;
                  else begin
                    idx <= search_start; state <= S_WKRD;
                  end
                end
              end
              OP_END: begin
                if (loaded_bins != '0) state <= S_DRAIN;
              end
              default: ;
            endcase
          end
        end
        S_LD1: state <= S_IDLE;
        S_SKRD: begin
          if (search_start < loaded_bins) state <= S_SKCK;
          else begin
            idx <= search_start; state <= S_WKRD;
          end
        end
        S_SKCK: begin
          if (lo_rd < min_start) begin
            search_start <= search_start + CW'(1); state <= S_SKRD;
          end else begin
            idx <= search_start; state <= S_WKRD;
          end
        end
        S_WKRD: state <= (idx < loaded_bins) ? S_WKCK : S_IDLE;
        S_WKCK: begin
          if (lo_rd > pk_mz) state <= S_IDLE;
          else if (pk_mz <= hi_rd) state <= S_WKWR;
          else begin
            idx <= idx + CW'(1); state <= S_WKRD;
          end
        end
        S_WKWR: begin
          idx <= idx + CW'(1); state <= S_WKRD;
        end
        S_DRAIN: begin
          if (issue) idx <= idx + CW'(1);
          if (idx == loaded_bins && in_flight == '0 && !out_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/tbpa_ram.sv */
// Generic single-port write, single-port registered-read RAM.
module tbpa_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/tbpa_scale.sv */
// Scaling of a sum by a Q16.16 weight with saturation: registered partial products, then a combinational sum.
module tbpa_scale import tbpa_pkg::*; (
  input  logic            clk,
  input  logic [SumW-1:0] sum,
  input  logic [31:0]     weight,
  output logic [SumW-1:0] scaled
);
  logic [63:0] part_hi;
  logic [63:0] part_lo;
  logic [64:0] total;
  always_ff @(posedge clk) begin
    part_hi <= sum * {48'd0, weight[31:16]};
    part_lo <= (sum * {48'd0, weight[15:0]}) >> 16;
  end
  assign total = {1'b0, part_hi} + {1'b0, part_lo};
  assign scaled = (part_hi > {16'd0, SUM_MAX} || total > {17'd0, SUM_MAX}) ? SUM_MAX
                : total[SumW-1:0];
endmodule

/* rtl/tbpa_checker.sv */
// Port-level checker for the tolerance bin peak accumulator, with its bind.
`include "tolerance_bin_peak_accumulator_defines.svh"
module tbpa_checker import tbpa_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            s_tvalid,
  input logic            s_tready,
  input logic [InW-1:0]  s_tdata,
  input logic            m_tvalid,
  input logic            m_tready,
  input logic [OutW-1:0] m_tdata,
  input logic            m_tlast
);
  `TBPA_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
  `TBPA_ASSERT_IMP(a_busy, clk, rst, m_tvalid, !s_tready,
    "input taken while results pending")
  `TBPA_ASSERT_NEXT(a_order, clk, rst, m_tvalid && m_tready && !m_tlast,
    !s_tready, "result run ended without last bin")
  `TBPA_ASSERT_IMP(a_pad, clk, rst, m_tvalid, m_tdata[OutW-1:70] == 2'd0,
    "output padding not zero")
endmodule

bind tolerance_bin_peak_accumulator tbpa_checker u_tbpa_checker (.*);

/* tb/tb_tolerance_bin_peak_accumulator.sv */
// Self-checking testbench for the tolerance bin peak accumulator stream block.
module tb_tolerance_bin_peak_accumulator;
  import tbpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS = 64;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] center;
    logic [23:0] half;
    logic [31:0] weight;
    logic [15:0] row;
    logic [31:0] mz;
    logic [31:0] inten;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  idx;
    logic [47:0] sum;
    logic [15:0] row;
    logic        last;
  } bin_result_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
  logic [InW-1:0] s_tdata;
  logic [OutW-1:0] m_tdata;

  tolerance_bin_peak_accumulator uut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predictor state.
  logic [31:0] lo_edge [NBINS];
  logic [31:0] hi_edge [NBINS];
  logic [47:0] bin_sum [NBINS];
  int unsigned n_loaded, scan_from;
  logic [31:0] max_half, prev_lo, prev_hi, range_lo, w_held;
  logic [15:0] row_held;
  logic beyond;

  bin_result_t expected_bins[$];
  int errors, mismatches, results_seen, items_sent;
  int idle_cycles = 0;
  int send_idle_pct, recv_stall_pct;
  logic timed_out = 1'b0;

  function automatic logic [47:0] scaled(logic [47:0] s, logic [31:0] w);
    logic [79:0] p;
    p = ({32'd0, s} * {48'd0, w}) >> 16;
    return (p > {32'd0, SUM_MAX}) ? SUM_MAX : p[47:0];
  endfunction

  task automatic predict(cmd_t c);
    logic [31:0] l, h, floor_mz;
    logic [33:0] s4;
    logic [48:0] acc;
    case (c.op)
      OP_CLEAR: begin
        for (int k = 0; k < NBINS; k++) bin_sum[k] = '0;
        n_loaded = 0; max_half = 0; prev_lo = 0; prev_hi = 0;
        range_lo = 0; scan_from = 0; beyond = 0;
      end
      OP_LOAD: if (n_loaded < NBINS) begin
        l = (c.center >= {8'd0, c.half}) ? c.center - c.half : 32'd0;
        h = (c.center > 32'hFFFFFFFF - c.half) ? 32'hFFFFFFFF : c.center + c.half;
        if ({8'd0, c.half} > max_half) max_half = {8'd0, c.half};
        lo_edge[n_loaded] = l;
        hi_edge[n_loaded] = h;
        if (n_loaded == 0) range_lo = l;
        else if (prev_hi > l) begin
          s4 = 34'(prev_lo) + 34'(prev_hi) + 34'(l) + 34'(h);
          hi_edge[n_loaded-1] = s4[33:2];
          lo_edge[n_loaded] = s4[33:2];
        end
        prev_lo = l; prev_hi = h;
        n_loaded++;
      end
      OP_START: begin
        w_held = c.weight; row_held = c.row;
        for (int k = 0; k < NBINS; k++) bin_sum[k] = '0;
        scan_from = 0; beyond = 0;
      end
      OP_PEAK: begin
        if (n_loaded != 0 && !beyond && c.mz >= range_lo) begin
          if (c.mz > prev_hi) beyond = 1;
          else begin
            if (c.mz >= max_half) begin
              floor_mz = c.mz - max_half;
              while (scan_from < n_loaded && lo_edge[scan_from] < floor_mz) scan_from++;
            end
            for (int j = scan_from; j < n_loaded; j++) begin
              if (lo_edge[j] > c.mz) break;
              if (c.mz <= hi_edge[j]) begin
                acc = {1'b0, bin_sum[j]} + c.inten;
                bin_sum[j] = acc[48] ? SUM_MAX : acc[47:0];
              end
            end
          end
        end
      end
      OP_END: for (int k = 0; k < n_loaded; k++)
        expected_bins.push_back('{6'(k), scaled(bin_sum[k], w_held), row_held,
                                  k + 1 == n_loaded});
      default: ;
    endcase
  endtask

  // The valid stays high after a transfer until the next item or an idle cycle.
  task automatic send(cmd_t c);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, c.inten, c.mz, c.row, c.weight, c.half, c.center, c.op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict(c);
    items_sent++;
  endtask

  function automatic cmd_t mk(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    cmd_t c;
    c = '{op: op, center: $urandom, half: 24'($urandom), weight: $urandom, row: 16'($urandom),
          mz: $urandom, inten: $urandom};
    case (op)
      OP_LOAD: begin c.center = a; c.half = b[23:0]; end
      OP_START: begin c.weight = a; c.row = b[15:0]; end
      OP_PEAK: begin c.mz = a; c.inten = b; end
      default: ;
    endcase
    return c;
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_bins.size() != 0 && !timed_out) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Checker and stall generator.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        bin_result_t got, want;
        got = '{m_tdata[5:0], m_tdata[53:6], m_tdata[69:54], m_tlast};
        results_seen++;
        if (expected_bins.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("Unexpected result %p", got);
        end else begin
          want = expected_bins.pop_front();
          if (got != want) begin
            errors++;
            if (mismatches++ < 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
      m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) timed_out <= 1'b1;
  end

  initial begin
    wait (timed_out === 1'b1);
    $display("Watchdog expired after %0d idle cycles", WATCHDOG);
    $display("Some tests failed");
    $finish;
  end

  // Directed rows: two spectra over overlapping, saturating and extreme bins.
  cmd_t directed[$];
  task automatic build_directed();
    directed = '{
      mk(OP_END, 0, 0),
      mk(OP_PEAK, 32'h10000, 5),
      mk(OP_LOAD, 32'h0001_0000, 24'h00_8000),
      mk(OP_LOAD, 32'h0001_4000, 24'h00_8000),
      mk(OP_LOAD, 32'h0100_0000, 24'hFF_FFFF),
      mk(OP_LOAD, 32'hFFFF_FFFF, 24'hFF_FFFF),
      mk(OP_START, 32'hFFFF_FFFF, 16'hFFFF),
      mk(OP_PEAK, 32'h0, 32'hFFFF_FFFF),
      mk(OP_PEAK, 32'h0000_C000, 32'hFFFF_FFFF),
      mk(OP_PEAK, 32'h0001_2000, 32'hFFFF_FFFF),
      mk(OP_PEAK, 32'h0100_0000, 32'hFFFF_FFFF),
      mk(OP_PEAK, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      mk(3'd5, 0, 0), mk(3'd6, 0, 0), mk(3'd7, 0, 0),
      mk(OP_END, 0, 0),
      mk(OP_PEAK, 32'hFFFF_FFFF, 1),
      mk(OP_START, 32'h0001_0000, 16'h0000),
      mk(OP_PEAK, 32'h0001_0000, 32'd7),
      mk(OP_END, 0, 0),
      mk(OP_CLEAR, 0, 0),
      mk(OP_END, 0, 0)
    };
  endtask

  task automatic random_spectrum(int nbins);
    logic [31:0] pos, mz;
    int npk;
    send(mk(OP_CLEAR, 0, 0));
    pos = $urandom_range(32'h0040_0000);
    for (int b = 0; b < nbins; b++) begin
      pos += $urandom_range(32'h0003_0000);
      send(mk(OP_LOAD, pos, $urandom_range(32'h0002_0000)));
    end
    if (nbins == NBINS || $urandom_range(9) == 0) send(mk(OP_LOAD, $urandom, $urandom));
    send(mk(OP_START, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000),
            $urandom));
    npk = $urandom_range(12);
    mz = pos - nbins * 32'h0002_0000 - $urandom_range(32'h0004_0000);
    for (int p = 0; p < npk; p++) begin
      mz += $urandom_range(32'h0002_0000);
      send(mk(OP_PEAK, ($urandom_range(15) == 0) ? $urandom : mz,
              ($urandom_range(7) == 0) ? $urandom : $urandom_range(1000)));
    end
    if ($urandom_range(7) == 0) send(mk(3'($urandom_range(5, 7)), 0, 0));
    send(mk(OP_END, 0, 0));
  endtask

  initial begin
    int phase;
    errors = 0; mismatches = 0; results_seen = 0; items_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    n_loaded = 0; scan_from = 0; max_half = 0; prev_lo = 0; prev_hi = 0; range_lo = 0;
    w_held = 0; row_held = 0; beyond = 0;
    for (int k = 0; k < NBINS; k++) bin_sum[k] = '0;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    build_directed();
    foreach (directed[i]) send(directed[i]);
    drain();

    // A full table, one load past it, then random sizes with and without input idling and output stalls.
    random_spectrum(NBINS);
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? 88 : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? 88 : 0;
      if (phase == 3) begin send_idle_pct = 12; recv_stall_pct = 12; end
      for (int s = 0; s < 4; s++) random_spectrum($urandom_range(1, 8));
      send_idle_pct = 0; recv_stall_pct = 0;
      for (int s = 0; s < 1; s++) random_spectrum($urandom_range(1, 8));
    end
    drain();

    $display("Sent %0d items over directed and random spectra, checked %0d bin results.",
             items_sent, results_seen);
    if (errors == 0 && expected_bins.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_bins.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
